// ----- hdl/lssc_pkg.sv -----
`timescale 1ns / 1ps
package lssc_pkg;

   localparam int unsigned MAX_HALVINGS = 16;
   localparam logic [30:0] OBJ_MAX      = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PROBE,
      PH_GROW,
      PH_SHRINK,
      PH_FIT
   } phase_type;

   typedef enum logic {
      CS_READY,
      CS_FIT
   } ctl_state_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_NORM,
      FS_MUL1,
      FS_MUL2,
      FS_MUL3,
      FS_MUL4,
      FS_PREP,
      FS_DIV
   } fit_state_type;

   typedef enum logic [1:0] {
      KIND_EVAL   = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_FAILED = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic        done;
      logic        ok;
      logic [31:0] step;
   } fit_rsp_type;

endpackage

// ----- hdl/lssc_fit.sv -----
`timescale 1ns / 1ps
module lssc_fit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          low_step,
   input  logic [31:0]          mid_step,
   input  logic [31:0]          high_step,
   input  logic [30:0]          low_obj,
   input  logic [30:0]          mid_obj,
   input  logic [30:0]          high_obj,
   output lssc_pkg::fit_rsp_type fit_rsp
);
   import lssc_pkg::*;

   fit_state_type      state_ff, state_in;
   logic [32:0]        mu_ff, mu_in, mw_ff, mw_in;
   logic               su_ff, su_in, sw_ff, sw_in;
   logic signed [31:0] p_ff, p_in, q_ff, q_in;
   logic [4:0]         s_ff, s_in;
   logic signed [48:0] m1_ff, m1_in, m2_ff, m2_in;
   logic signed [63:0] m3_ff, m3_in, m4_ff, m4_in;
   logic [63:0]        nm_ff, nm_in;
   logic [49:0]        dm_ff, dm_in;
   logic [49:0]        rem_ff, rem_in;
   logic               qneg_ff, qneg_in;
   logic [5:0]         cnt_ff, cnt_in;
   fit_rsp_type        rsp_ff, rsp_in;
   logic               post_ff, post_in;

   logic signed [32:0] u_d, w_d;
   logic signed [16:0] us, ws;
   logic signed [48:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [65:0] prod;
   logic signed [63:0] num;
   logic signed [49:0] den;
   logic [50:0]        rem_sh;
   logic               ge;
   logic               big;
   logic [51:0]        delta;
   logic [52:0]        sum;

   assign fit_rsp = rsp_ff;

   // scaled offsets, truncated toward zero
   assign us = su_ff ? -$signed({2'b00, mu_ff[14:0]}) : $signed({2'b00, mu_ff[14:0]});
   assign ws = sw_ff ? -$signed({2'b00, mw_ff[14:0]}) : $signed({2'b00, mw_ff[14:0]});

   always_comb begin
      case (state_ff)
         FS_MUL1: begin mul_a = 49'(q_ff); mul_b = us; end
         FS_MUL2: begin mul_a = 49'(p_ff); mul_b = ws; end
         FS_MUL3: begin mul_a = m1_ff;     mul_b = us; end
         default: begin mul_a = m2_ff;     mul_b = ws; end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign rem_sh = {rem_ff[49:0], nm_ff[63]};
   assign ge     = rem_sh >= {1'b0, dm_ff};
   assign big    = (|nm_ff[63:34]) || (nm_ff[33] && (|nm_ff[32:0]));
   assign delta  = {18'd0, nm_ff[33:0]} << s_ff;
   assign sum    = {21'd0, mid_step} + {1'b0, delta};

   always_comb begin
      state_in = state_ff;
      mu_in    = mu_ff;
      mw_in    = mw_ff;
      su_in    = su_ff;
      sw_in    = sw_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      s_in     = s_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      m3_in    = m3_ff;
      m4_in    = m4_ff;
      nm_in    = nm_ff;
      dm_in    = dm_ff;
      rem_in   = rem_ff;
      qneg_in  = qneg_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;
      rsp_in.done = 1'b0;
      u_d = $signed({1'b0, mid_step}) - $signed({1'b0, low_step});
      w_d = $signed({1'b0, high_step}) - $signed({1'b0, mid_step});
      num = m3_ff + m4_ff;
      den = {m1_ff - m2_ff, 1'b0};
      case (state_ff)
         FS_IDLE: begin
            if (start) begin
               su_in    = u_d[32];
               sw_in    = w_d[32];
               mu_in    = u_d[32] ? 33'(-u_d) : u_d;
               mw_in    = w_d[32] ? 33'(-w_d) : w_d;
               p_in     = $signed({1'b0, mid_obj}) - $signed({1'b0, low_obj});
               q_in     = $signed({1'b0, high_obj}) - $signed({1'b0, mid_obj});
               s_in     = 5'd0;
               state_in = FS_NORM;
            end
         end
         FS_NORM: begin
            // one shift a cycle until both offsets fit in 15 bits
            if (|(mu_ff[32:15] | mw_ff[32:15])) begin
               mu_in = mu_ff >> 1;
               mw_in = mw_ff >> 1;
               s_in  = s_ff + 5'd1;
            end else begin
               state_in = FS_MUL1;
            end
         end
         FS_MUL1: begin m1_in = prod[48:0]; state_in = FS_MUL2; end
         FS_MUL2: begin m2_in = prod[48:0]; state_in = FS_MUL3; end
         FS_MUL3: begin m3_in = prod[63:0]; state_in = FS_MUL4; end
         FS_MUL4: begin m4_in = prod[63:0]; state_in = FS_PREP; end
         FS_PREP: begin
            if (m1_ff == m2_ff) begin
               rsp_in.done = 1'b1;
               rsp_in.ok   = 1'b0;
               state_in    = FS_IDLE;
            end else begin
               nm_in    = num[63] ? 64'(-num) : num;
               dm_in    = den[49] ? 50'(-den) : den;
               qneg_in  = num[63] ^ den[49];
               rem_in   = '0;
               cnt_in   = 6'd63;
               state_in = FS_DIV;
            end
         end
         FS_DIV: begin
            rem_in = ge ? 50'(rem_sh - {1'b0, dm_ff}) : rem_sh[49:0];
            nm_in  = {nm_ff[62:0], ge};
            cnt_in = cnt_ff - 6'd1;
            // last quotient bit lands at this edge; the step is formed in the following cycle
            if (cnt_ff == 6'd0) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   // quotient final evaluation in the cycle after the divider stops
   assign post_in = (state_ff == FS_DIV) && (cnt_ff == 6'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         rsp_ff   <= '0;
         post_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         post_ff  <= post_in;
         if (post_ff) begin
            rsp_ff.done <= 1'b1;
            if (qneg_ff) begin
               rsp_ff.ok   <= !big && (sum[52:32] == 21'd0);
               rsp_ff.step <= sum[31:0];
            end else begin
               rsp_ff.ok   <= !big && (delta <= {20'd0, mid_step});
               rsp_ff.step <= mid_step - delta[31:0];
            end
         end else begin
            rsp_ff <= rsp_in;
         end
      end
      mu_ff   <= mu_in;
      mw_ff   <= mw_in;
      su_ff   <= su_in;
      sw_ff   <= sw_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      s_ff    <= s_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      m3_ff   <= m3_in;
      m4_ff   <= m4_in;
      nm_ff   <= nm_in;
      dm_ff   <= dm_in;
      rem_ff  <= rem_in;
      qneg_ff <= qneg_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ----- hdl/line_search_step_controller.sv -----
`timescale 1ns / 1ps
// Flow: start beats and bracketing beats give their request in the cycle after acceptance.
// A beat that triggers the parabola fit runs up to 17 normalising shifts, four passes
// through the shared 49x17 multiplier and, unless the fit is degenerate, a 64-step
// restoring divider.
// Throughput: one beat at a time; req_ready is low while the fit unit runs or a result beat waits.
// Reset: synchronous, active high; search phase goes idle and the output beat is dropped.
module line_search_step_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_initial_step,
   input  logic [30:0] req_base_objective,
   input  logic signed [31:0] req_objective_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_step,
   output logic [30:0] rsp_final_objective,
   output logic        rsp_last
);
   import lssc_pkg::*;

   ctl_state_type   ctl_ff, ctl_in;
   phase_type       phase_ff, phase_in;
   logic [31:0]     low_step_ff, low_step_in, mid_step_ff, mid_step_in;
   logic [31:0]     high_step_ff, high_step_in, fit_step_ff, fit_step_in;
   logic [30:0]     low_obj_ff, low_obj_in, mid_obj_ff, mid_obj_in;
   logic [30:0]     high_obj_ff, high_obj_in;
   logic [4:0]      halv_ff, halv_in;
   logic            fit_start_ff, fit_start_in;

   logic            rsp_valid_ff, rsp_valid_in;
   result_kind_type rsp_kind_ff, rsp_kind_in;
   logic [31:0]     rsp_step_ff, rsp_step_in;
   logic [30:0]     rsp_fobj_ff, rsp_fobj_in;
   logic            rsp_last_ff, rsp_last_in;

   fit_rsp_type     fit_rsp;
   logic            accept;
   logic            err;
   logic [30:0]     val;
   logic [30:0]     grow_val;

   lssc_fit u_fit (
      .clock     (clock),
      .reset     (reset),
      .start     (fit_start_ff),
      .low_step  (low_step_ff),
      .mid_step  (mid_step_ff),
      .high_step (high_step_ff),
      .low_obj   (low_obj_ff),
      .mid_obj   (mid_obj_ff),
      .high_obj  (high_obj_ff),
      .fit_rsp   (fit_rsp)
   );

   // output register frees itself in the same cycle it is taken
   assign req_ready = (ctl_ff == CS_READY) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign err       = req_objective_value[31];
   assign val       = req_objective_value[30:0];
   // an error while growing counts as four times the midpoint, saturated
   assign grow_val  = err ? ((|mid_obj_ff[30:29]) ? OBJ_MAX : {mid_obj_ff[28:0], 2'b00})
                          : val;

   always_comb begin
      ctl_in       = ctl_ff;
      phase_in     = phase_ff;
      low_step_in  = low_step_ff;
      mid_step_in  = mid_step_ff;
      high_step_in = high_step_ff;
      fit_step_in  = fit_step_ff;
      low_obj_in   = low_obj_ff;
      mid_obj_in   = mid_obj_ff;
      high_obj_in  = high_obj_ff;
      halv_in      = halv_ff;
      fit_start_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_fobj_in  = rsp_fobj_ff;
      rsp_last_in  = rsp_last_ff;
      case (ctl_ff)
         CS_READY: begin
            if (accept) begin
               rsp_kind_in = KIND_EVAL;
               rsp_fobj_in = '0;
               rsp_last_in = 1'b0;
               if (!req_mode) begin
                  low_step_in  = '0;
                  low_obj_in   = req_base_objective;
                  high_step_in = req_initial_step;
                  halv_in      = '0;
                  phase_in     = PH_PROBE;
                  rsp_valid_in = 1'b1;
                  rsp_step_in  = req_initial_step;
               end else begin
                  case (phase_ff)
                     PH_PROBE: begin
                        rsp_valid_in = 1'b1;
                        if (err) begin
                           high_step_in = high_step_ff >> 1;
                           rsp_step_in  = high_step_ff >> 1;
                        end else begin
                           high_obj_in = val;
                           if (val < low_obj_ff) begin
                              if (high_step_ff[31]) begin
                                 phase_in    = PH_IDLE;
                                 rsp_kind_in = KIND_DONE;
                                 rsp_step_in = high_step_ff;
                                 rsp_fobj_in = val;
                                 rsp_last_in = 1'b1;
                              end else begin
                                 mid_step_in  = high_step_ff;
                                 mid_obj_in   = val;
                                 high_step_in = high_step_ff << 1;
                                 phase_in     = PH_GROW;
                                 rsp_step_in  = high_step_ff << 1;
                              end
                           end else begin
                              mid_step_in = high_step_ff >> 1;
                              halv_in     = '0;
                              phase_in    = PH_SHRINK;
                              rsp_step_in = high_step_ff >> 1;
                           end
                        end
                     end
                     PH_GROW: begin
                        high_obj_in = grow_val;
                        if (grow_val < mid_obj_ff) begin
                           rsp_valid_in = 1'b1;
                           if (high_step_ff[31]) begin
                              phase_in    = PH_IDLE;
                              rsp_kind_in = KIND_DONE;
                              rsp_step_in = high_step_ff;
                              rsp_fobj_in = grow_val;
                              rsp_last_in = 1'b1;
                           end else begin
                              low_step_in  = mid_step_ff;
                              low_obj_in   = mid_obj_ff;
                              mid_step_in  = high_step_ff;
                              mid_obj_in   = grow_val;
                              high_step_in = high_step_ff << 1;
                              rsp_step_in  = high_step_ff << 1;
                           end
                        end else begin
                           ctl_in       = CS_FIT;
                           fit_start_in = 1'b1;
                        end
                     end
                     PH_SHRINK: begin
                        if (err || val > low_obj_ff) begin
                           rsp_valid_in = 1'b1;
                           if (32'(halv_ff) >= MAX_HALVINGS) begin
                              phase_in    = PH_IDLE;
                              rsp_kind_in = KIND_FAILED;
                              rsp_step_in = '0;
                              rsp_last_in = 1'b1;
                           end else begin
                              halv_in      = halv_ff + 5'd1;
                              high_step_in = mid_step_ff;
                              high_obj_in  = err ? OBJ_MAX : val;
                              mid_step_in  = mid_step_ff >> 1;
                              rsp_step_in  = mid_step_ff >> 1;
                           end
                        end else begin
                           mid_obj_in   = val;
                           ctl_in       = CS_FIT;
                           fit_start_in = 1'b1;
                        end
                     end
                     PH_FIT: begin
                        rsp_valid_in = 1'b1;
                        phase_in     = PH_IDLE;
                        rsp_kind_in  = KIND_DONE;
                        rsp_last_in  = 1'b1;
                        if (!err && val <= mid_obj_ff) begin
                           rsp_step_in = fit_step_ff;
                           rsp_fobj_in = val;
                        end else begin
                           rsp_step_in = mid_step_ff;
                           rsp_fobj_in = mid_obj_ff;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         CS_FIT: begin
            if (fit_rsp.done) begin
               ctl_in       = CS_READY;
               rsp_valid_in = 1'b1;
               if (fit_rsp.ok) begin
                  fit_step_in = fit_rsp.step;
                  phase_in    = PH_FIT;
                  rsp_kind_in = KIND_EVAL;
                  rsp_step_in = fit_rsp.step;
                  rsp_fobj_in = '0;
                  rsp_last_in = 1'b0;
               end else begin
                  // degenerate or out-of-range fit: settle on the midpoint
                  phase_in    = PH_IDLE;
                  rsp_kind_in = KIND_DONE;
                  rsp_step_in = mid_step_ff;
                  rsp_fobj_in = mid_obj_ff;
                  rsp_last_in = 1'b1;
               end
            end
         end
         default: ctl_in = CS_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CS_READY;
         phase_ff     <= PH_IDLE;
         halv_ff      <= '0;
         fit_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         low_step_ff  <= '0;
         mid_step_ff  <= '0;
         high_step_ff <= '0;
         fit_step_ff  <= '0;
         low_obj_ff   <= '0;
         mid_obj_ff   <= '0;
         high_obj_ff  <= '0;
      end else begin
         ctl_ff       <= ctl_in;
         phase_ff     <= phase_in;
         halv_ff      <= halv_in;
         fit_start_ff <= fit_start_in;
         rsp_valid_ff <= rsp_valid_in;
         low_step_ff  <= low_step_in;
         mid_step_ff  <= mid_step_in;
         high_step_ff <= high_step_in;
         fit_step_ff  <= fit_step_in;
         low_obj_ff   <= low_obj_in;
         mid_obj_ff   <= mid_obj_in;
         high_obj_ff  <= high_obj_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_step_ff <= rsp_step_in;
      rsp_fobj_ff <= rsp_fobj_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_step            = rsp_step_ff;
   assign rsp_final_objective = rsp_fobj_ff;
   assign rsp_last            = rsp_last_ff;

   // fit result may only land on an empty output register
   a_fit_lands_empty: assert property (@(posedge clock) disable iff (reset)
      fit_rsp.done |-> (ctl_ff == CS_FIT) && !rsp_valid_ff)
      else $error("fit result with output beat pending");

   a_last_not_eval: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_kind_ff != KIND_EVAL))
      else $error("closing beat carries an evaluate request");

   a_halving_bound: assert property (@(posedge clock) disable iff (reset)
      32'(halv_ff) <= MAX_HALVINGS)
      else $error("halving count past limit");

   a_fit_start_once: assert property (@(posedge clock) disable iff (reset)
      fit_start_ff |-> (ctl_ff == CS_FIT) && !$past(fit_start_ff))
      else $error("fit unit started twice");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
   import lssc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic        mode;
      logic [31:0] initial_step;
      logic [30:0] base_objective;
      logic [31:0] objective_value;
   } search_beat_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] step;
      logic [30:0] final_objective;
      logic        last;
   } step_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [31:0] req_initial_step = '0;
   logic [30:0] req_base_objective = '0;
   logic signed [31:0] req_objective_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [31:0] rsp_step;
   logic [30:0] rsp_final_objective;
   logic        rsp_last;

   line_search_step_controller dut (.*);

   always #6 clock = ~clock;

   // pending beats for the driver, expected results for the monitor
   search_beat_type beat_queue[$];
   step_result_type expected_results[$];
   int  error_count = 0;
   bit  stimulus_done = 0;
   bit  quiet_mode = 0;     // no idling on either side
   bit  hold_rsp = 0;       // long receiver hold-off request
   int  hold_cycles = 0;
   int  idle_cycles = 0;

   // predictor copy of the controller state
   phase_type   ph_state = PH_IDLE;
   logic [31:0] lo_st, md_st, hi_st, fit_st;
   logic [31:0] lo_ob, md_ob, hi_ob;
   int unsigned halvings;

   function automatic step_result_type mk(logic [1:0] k, logic [31:0] s, logic [31:0] o,
                                          logic l);
      step_result_type r;
      r.kind = k; r.step = s; r.final_objective = o[30:0]; r.last = l;
      return r;
   endfunction

   function automatic bit fit_parabola(output logic [31:0] res);
      longint u, w, p, q, scale, us, ws, num, den, t, x;
      longint unsigned mu, mw, mag;
      int sh;
      u = longint'(md_st) - longint'(lo_st);
      w = longint'(hi_st) - longint'(md_st);
      p = longint'(md_ob) - longint'(lo_ob);
      q = longint'(hi_ob) - longint'(md_ob);
      mu = u < 0 ? -u : u;
      mw = w < 0 ? -w : w;
      mag = mu > mw ? mu : mw;
      sh = 0;
      res = '0;
      while (mag >= 32768) begin
         mag = mag >> 1;
         sh++;
      end
      scale = longint'(1) << sh;
      us = u / scale;
      ws = w / scale;
      num = q * us * us + p * ws * ws;
      den = 2 * (q * us - p * ws);
      if (den == 0) return 0;
      t = -(num / den);
      if (t > (longint'(1) << 33) || t < -(longint'(1) << 33)) return 0;
      x = longint'(md_st) + t * scale;
      if (x < 0 || x > 64'hFFFF_FFFF) return 0;
      res = x[31:0];
      return 1;
   endfunction

   function automatic step_result_type close_search(logic [31:0] s, logic [31:0] o);
      ph_state = PH_IDLE;
      return mk(KIND_DONE, s, o, 1'b1);
   endfunction

   function automatic step_result_type begin_fit();
      logic [31:0] f;
      if (!fit_parabola(f)) return close_search(md_st, md_ob);
      fit_st = f;
      ph_state = PH_FIT;
      return mk(KIND_EVAL, f, 0, 1'b0);
   endfunction

   // returns 1 when the beat causes a result
   function automatic bit predict_step(search_beat_type b, output step_result_type r);
      logic [31:0] v;
      logic        err;
      longint unsigned x4;
      v = b.objective_value;
      err = v[31];
      r = '0;
      if (b.mode == 1'b0) begin
         lo_st = 0;
         lo_ob = {1'b0, b.base_objective};
         hi_st = b.initial_step;
         halvings = 0;
         ph_state = PH_PROBE;
         r = mk(KIND_EVAL, hi_st, 0, 1'b0);
         return 1;
      end
      case (ph_state)
         PH_PROBE: begin
            if (err) begin
               hi_st = hi_st >> 1;
               r = mk(KIND_EVAL, hi_st, 0, 1'b0);
               return 1;
            end
            hi_ob = v;
            if (v < lo_ob) begin
               if (hi_st[31]) begin
                  r = close_search(hi_st, v);
                  return 1;
               end
               md_st = hi_st;
               md_ob = v;
               hi_st = hi_st << 1;
               ph_state = PH_GROW;
               r = mk(KIND_EVAL, hi_st, 0, 1'b0);
               return 1;
            end
            md_st = hi_st >> 1;
            halvings = 0;
            ph_state = PH_SHRINK;
            r = mk(KIND_EVAL, md_st, 0, 1'b0);
            return 1;
         end
         PH_GROW: begin
            if (err) begin
               // an error reads as four times the midpoint, saturated
               x4 = longint'(md_ob) << 2;
               v = x4 > OBJ_MAX ? {1'b0, OBJ_MAX} : x4[31:0];
            end
            hi_ob = v;
            if (v < md_ob) begin
               if (hi_st[31]) begin
                  r = close_search(hi_st, v);
                  return 1;
               end
               lo_st = md_st; lo_ob = md_ob;
               md_st = hi_st; md_ob = v;
               hi_st = hi_st << 1;
               r = mk(KIND_EVAL, hi_st, 0, 1'b0);
               return 1;
            end
            r = begin_fit();
            return 1;
         end
         PH_SHRINK: begin
            if (err || v > lo_ob) begin
               if (halvings >= MAX_HALVINGS) begin
                  ph_state = PH_IDLE;
                  r = mk(KIND_FAILED, 0, 0, 1'b1);
                  return 1;
               end
               halvings++;
               hi_st = md_st;
               hi_ob = err ? {1'b0, OBJ_MAX} : v;
               md_st = md_st >> 1;
               r = mk(KIND_EVAL, md_st, 0, 1'b0);
               return 1;
            end
            md_ob = v;
            r = begin_fit();
            return 1;
         end
         PH_FIT: begin
            if (!err && v <= md_ob) r = close_search(fit_st, v);
            else r = close_search(md_st, md_ob);
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   // Driver: one beat held until accepted; prediction at acceptance.
   always @(posedge clock) begin
      step_result_type r;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (predict_step({req_mode, req_initial_step, req_base_objective,
                              req_objective_value}, r))
               expected_results.push_back(r);
         end
         if (!req_valid || req_ready) begin
            if (beat_queue.size() > 0 && (quiet_mode || $urandom_range(99) >= 22)) begin
               req_valid           <= 1'b1;
               req_mode            <= beat_queue[0].mode;
               req_initial_step    <= beat_queue[0].initial_step;
               req_base_objective  <= beat_queue[0].base_objective;
               req_objective_value <= beat_queue[0].objective_value;
               void'(beat_queue.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      step_result_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t unexpected result beat kind=%0d step=%h", $time,
                        rsp_result_kind, rsp_step);
               error_count++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_result_kind !== e.kind) begin
                  $display("%0t kind exp %0d act %0d", $time, e.kind, rsp_result_kind);
                  error_count++;
               end
               if (rsp_step !== e.step) begin
                  $display("%0t step exp %h act %h", $time, e.step, rsp_step);
                  error_count++;
               end
               if (rsp_final_objective !== e.final_objective) begin
                  $display("%0t objective exp %h act %h", $time, e.final_objective,
                           rsp_final_objective);
                  error_count++;
               end
               if (rsp_last !== e.last) begin
                  $display("%0t last exp %b act %b", $time, e.last, rsp_last);
                  error_count++;
               end
            end
         end
         // long hold-off counted here so the sender keeps offering meanwhile
         if (hold_rsp && hold_cycles == 0) hold_cycles = 300;
         if (hold_cycles > 0) begin
            hold_cycles--;
            if (hold_cycles == 0) hold_rsp = 0;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_mode || ($urandom_range(99) >= 22);
         end
      end
   end

   // Watchdog: cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic search_beat_type start_beat(logic [31:0] s, logic [30:0] b);
      search_beat_type x;
      x = '0; x.mode = 1'b0; x.initial_step = s; x.base_objective = b;
      x.objective_value = $urandom;
      return x;
   endfunction

   function automatic search_beat_type obj_beat(logic [31:0] v);
      search_beat_type x;
      x.mode = 1'b1; x.initial_step = $urandom; x.base_objective = 31'($urandom);
      x.objective_value = v;
      return x;
   endfunction

   // Objective chosen to steer the search: improving, worsening or out of range.
   function automatic logic [31:0] steer_value(logic [31:0] base);
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return 32'h8000_0000 | $urandom;
      if (sel < 5 && base > 0) return $urandom_range(base - 1);
      if (sel < 9) return base + $urandom_range(1000);
      return $urandom & 32'h7FFF_FFFF;
   endfunction

   task automatic wait_drained();
      while (beat_queue.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int sent;
      int len;
      logic [30:0] b;
      bit held_once;
      bit drained_once;
      // reset held high at start, then released
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: idle delivery, extremes, errors, overflow, failure, fits
      beat_queue.push_back(obj_beat(32'd5));
      beat_queue.push_back(start_beat(32'hFFFF_FFFF, 31'h7FFF_FFFF));
      beat_queue.push_back(obj_beat(32'h8000_0000));
      beat_queue.push_back(obj_beat(32'h8000_0000));
      beat_queue.push_back(obj_beat(32'd10));
      beat_queue.push_back(obj_beat(32'd5));
      beat_queue.push_back(obj_beat(32'hFFFF_FFFF));
      beat_queue.push_back(start_beat(32'h8000_0000, 31'd100));
      beat_queue.push_back(obj_beat(32'd50));
      beat_queue.push_back(start_beat(32'd0, 31'd0));
      beat_queue.push_back(obj_beat(32'h8000_0000));
      beat_queue.push_back(obj_beat(32'd1));
      for (int i = 0; i < 17; i++) beat_queue.push_back(obj_beat(32'h7FFF_FFFF));
      beat_queue.push_back(start_beat(32'h0001_0000, 31'h0010_0000));
      beat_queue.push_back(obj_beat(32'h0008_0000));
      beat_queue.push_back(obj_beat(32'h0004_0000));
      beat_queue.push_back(obj_beat(32'h8000_0000));
      beat_queue.push_back(obj_beat(32'h0000_1000));
      wait_drained();
      repeat (100) @(posedge clock);

      sent = 0;
      held_once = 1'b0;
      drained_once = 1'b0;
      while (sent < 1700) begin
         if (sent > 500 && !held_once) begin
            held_once = 1'b1;
            hold_rsp = 1;
            while (hold_rsp) begin
               if (beat_queue.size() < 4) begin
                  beat_queue.push_back(start_beat($urandom, 31'($urandom)));
                  sent++;
               end
               @(posedge clock);
            end
         end
         if (sent > 900 && sent < 1000) quiet_mode = 1;
         else quiet_mode = 0;
         if (sent > 1200 && !drained_once) begin
            drained_once = 1'b1;
            wait_drained();
         end
         // mostly well-formed searches with small initial steps
         b = 31'($urandom);
         if ($urandom_range(3) == 0) b = 31'($urandom_range(2000));
         beat_queue.push_back(start_beat($urandom_range(3) == 0 ? $urandom :
                                         $urandom_range(32'h0004_0000), b));
         len = $urandom_range(1, 25);
         for (int i = 0; i < len; i++) beat_queue.push_back(obj_beat(steer_value(b)));
         if ($urandom_range(9) == 0) beat_queue.push_back(obj_beat($urandom));
         sent += len + 1;
         while (beat_queue.size() > 30) @(posedge clock);
      end
      quiet_mode = 0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
